@@ hdl/fpp_pkg.sv @@
// fpp_pkg: shared constants, types and check functions of the framed packet parser
// used by fpp_front, fpp_back and framed_packet_parser_checked_core
`default_nettype none

package fpp_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;

  // widest length and index over the whole parameter range
  localparam int LEN_MAX_W = 7;
  localparam int IDX_MAX_W = 6;

  localparam int PAYLOAD_LEN_W = 6;
  localparam int BYTE_INDEX_W  = 5;

  localparam logic [7:0]  HEADER_RESET = 8'hAA;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;

  localparam logic [1:0] MODE_SUM = 2'd0;
  localparam logic [1:0] MODE_CRC = 2'd1;

  localparam logic REG_HEADER = 1'b0;
  localparam logic REG_MODE   = 1'b1;

  typedef struct packed {
    logic                 en;
    logic                 bank;
    logic [IDX_MAX_W-1:0] idx;
    logic [7:0]           data;
  } fpp_wr_t;

  typedef struct packed {
    logic                 bank;
    logic [7:0]           addr;
    logic [7:0]           id;
    logic [LEN_MAX_W-1:0] len;
  } fpp_desc_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [15:0] fold_check(input logic [1:0] mode, input logic [15:0] acc,
                                             input logic [7:0] b);
    logic [7:0]  s;
    logic [15:0] r;
    s = acc[7:0] + b;
    unique case (mode)
      MODE_SUM: r = {8'h00, s};
      MODE_CRC: r = crc_byte(acc, b);
      default:  r = 16'h0000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/fpp_front.sv @@
// fpp_front: byte parser, running check, config registers and two-slot frame queue
// depends on fpp_pkg; feeds payload writes and frame descriptors to fpp_back
`default_nettype none

module fpp_front
  import fpp_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  output fpp_wr_t         wr_o,
  output logic            desc_valid_o,
  output fpp_desc_t       desc_o,
  input  wire logic       desc_pop_i
);

  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_ADDRESS,
    PH_ID,
    PH_LENGTH,
    PH_DATA,
    PH_CHK_HI,
    PH_CHK_LO
  } phase_e;

  phase_e           phase_q;
  logic [7:0]       header_q;
  logic [1:0]       mode_q;
  logic [LEN_W-1:0] cnt_q, len_q, cnt_inc;
  logic [7:0]       addr_q, id_q, chk_hi_q;
  logic [15:0]      chk_q, chk_fold, expect_chk;
  logic             wbank_q, rbank_q;
  logic [1:0]       busy_q, busy_d;
  logic [7:0]       slot_addr_q [2];
  logic [7:0]       slot_id_q [2];
  logic [LEN_W-1:0] slot_len_q [2];
  logic             accept, match;

  assign full     = busy_q[wbank_q];
  assign accept   = push && !full;
  assign chk_fold = fold_check(mode_q, chk_q, rx_byte_i);
  assign cnt_inc  = cnt_q + LEN_W'(1);

  always_comb begin
    unique case (mode_q)
      MODE_SUM: expect_chk = {8'h00, chk_q[7:0]};
      MODE_CRC: expect_chk = chk_q;
      default:  expect_chk = 16'h0000;
    endcase
  end

  assign match = ({chk_hi_q, rx_byte_i} == expect_chk);

  // slot occupancy: the back side frees one slot, a matched frame fills the other
  always_comb begin
    busy_d = busy_q;
    if (desc_pop_i) begin
      busy_d[rbank_q] = 1'b0;
    end
    if (accept && (phase_q == PH_CHK_LO) && match) begin
      busy_d[wbank_q] = 1'b1;
    end
  end

  assign wr_o.en   = accept && (phase_q == PH_DATA);
  assign wr_o.bank = wbank_q;
  assign wr_o.idx  = IDX_MAX_W'(cnt_q);
  assign wr_o.data = rx_byte_i;

  assign desc_valid_o = busy_q[rbank_q];
  assign desc_o.bank  = rbank_q;
  assign desc_o.addr  = slot_addr_q[rbank_q];
  assign desc_o.id    = slot_id_q[rbank_q];
  assign desc_o.len   = LEN_MAX_W'(slot_len_q[rbank_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      header_q <= HEADER_RESET;
      mode_q   <= MODE_SUM;
      cnt_q    <= '0;
      len_q    <= '0;
      addr_q   <= '0;
      id_q     <= '0;
      chk_q    <= '0;
      chk_hi_q <= '0;
      wbank_q  <= 1'b0;
      rbank_q  <= 1'b0;
      busy_q   <= '0;
    end else begin
      busy_q <= busy_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_HEADER: header_q <= cfg_data_i;
          REG_MODE:   mode_q   <= cfg_data_i[1:0];
          default:    ;
        endcase
      end
      if (desc_pop_i) begin
        rbank_q <= ~rbank_q;
      end
      if (accept) begin
        unique case (phase_q)
          PH_ADDRESS: begin
            addr_q  <= rx_byte_i;
            chk_q   <= chk_fold;
            phase_q <= PH_ID;
          end
          PH_ID: begin
            id_q    <= rx_byte_i;
            chk_q   <= chk_fold;
            phase_q <= PH_LENGTH;
          end
          PH_LENGTH: begin
            if (rx_byte_i > 8'(MAX_PAYLOAD)) begin
              phase_q <= PH_HEADER;
            end else begin
              len_q   <= LEN_W'(rx_byte_i);
              cnt_q   <= '0;
              chk_q   <= chk_fold;
              phase_q <= (rx_byte_i != 8'd0) ? PH_DATA : PH_CHK_HI;
            end
          end
          PH_DATA: begin
            chk_q <= chk_fold;
            cnt_q <= cnt_inc;
            if (cnt_inc >= len_q) begin
              phase_q <= PH_CHK_HI;
            end
          end
          PH_CHK_HI: begin
            chk_hi_q <= rx_byte_i;
            phase_q  <= PH_CHK_LO;
          end
          PH_CHK_LO: begin
            phase_q <= PH_HEADER;
            if (match) begin
              slot_addr_q[wbank_q] <= addr_q;
              slot_id_q[wbank_q]   <= id_q;
              slot_len_q[wbank_q]  <= len_q;
              wbank_q              <= ~wbank_q;
            end
          end
          default: begin
            if (rx_byte_i == header_q) begin
              chk_q   <= fold_check(mode_q, (mode_q == MODE_CRC) ? CRC_INIT : 16'h0000,
                                    rx_byte_i);
              phase_q <= PH_ADDRESS;
            end
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/fpp_back.sv @@
// fpp_back: payload memory (two banks) and result sequencer
// depends on fpp_pkg; takes frame descriptors from fpp_front
`default_nettype none

module fpp_back
  import fpp_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire fpp_wr_t                  wr_i,
  input  wire logic                     desc_valid_i,
  input  wire fpp_desc_t                desc_i,
  output logic                          desc_pop_o,
  output logic                          empty,
  input  wire logic                     pop,
  output logic [7:0]                    frame_address_o,
  output logic [7:0]                    frame_id_o,
  output logic [PAYLOAD_LEN_W-1:0]      payload_length_o,
  output logic                          has_payload_o,
  output logic [BYTE_INDEX_W-1:0]       byte_index_o,
  output logic [7:0]                    payload_byte_o,
  output logic                          last_o
);

  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int AW    = IDX_W + 1;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_SHOW
  } back_e;

  back_e                state_q;
  logic [IDX_W-1:0]     idx_q;
  logic [7:0]           mem [2**AW];
  logic [7:0]           rd_q;
  logic [IDX_MAX_W-1:0] idx_ext;
  logic                 has_pl;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[{wr_i.bank, wr_i.idx[IDX_W-1:0]}] <= wr_i.data;
    end
    rd_q <= mem[{desc_i.bank, idx_q}];
  end

  assign idx_ext          = IDX_MAX_W'(idx_q);
  assign has_pl           = (desc_i.len != '0);
  assign empty            = (state_q != BK_SHOW);
  assign frame_address_o  = desc_i.addr;
  assign frame_id_o       = desc_i.id;
  assign payload_length_o = desc_i.len[PAYLOAD_LEN_W-1:0];
  assign has_payload_o    = has_pl;
  assign byte_index_o     = idx_ext[BYTE_INDEX_W-1:0];
  assign payload_byte_o   = has_pl ? rd_q : 8'h00;
  assign last_o           = !has_pl
                            || ((LEN_MAX_W'(idx_q) + LEN_MAX_W'(1)) == desc_i.len);
  assign desc_pop_o       = (state_q == BK_SHOW) && pop && last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        BK_IDLE: begin
          if (desc_valid_i) begin
            idx_q   <= '0;
            state_q <= BK_FETCH;
          end
        end
        BK_FETCH: state_q <= BK_SHOW;
        BK_SHOW: begin
          if (pop) begin
            if (last_o) begin
              state_q <= BK_IDLE;
            end else begin
              idx_q   <= idx_q + IDX_W'(1);
              state_q <= BK_FETCH;
            end
          end
        end
        default: state_q <= BK_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/framed_packet_parser_checked_core.sv @@
// framed_packet_parser_checked_core: top level of the framed packet parser
// depends on fpp_pkg, fpp_front and fpp_back
`default_nettype none

// Received bytes are taken one per clock while full is low. A frame is header,
// address, id, length, payload and a 16-bit check sent high byte first; the check is
// an 8-bit sum or CRC-16 (poly 0x1021, init 0xFFFF) per the mode register, or zero
// in the other two modes. A frame whose check matches is parked in one of two payload
// banks and then emitted as one word per payload byte (one word for an empty frame).
// Each result word passes through a fetch from the payload memory's registered read
// port and then the word on show, where it waits for pop; the first word of a frame
// also goes through the idle state, left once the frame is queued. full rises only
// while both banks hold matched frames that are not yet fully popped.

module framed_packet_parser_checked_core
  import fpp_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic [7:0]               rx_byte_i,
  input  wire logic                     cfg_we_i,
  input  wire logic                     cfg_idx_i,
  input  wire logic [7:0]               cfg_data_i,
  output logic                          empty,
  input  wire logic                     pop,
  output logic [7:0]                    frame_address_o,
  output logic [7:0]                    frame_id_o,
  output logic [PAYLOAD_LEN_W-1:0]      payload_length_o,
  output logic                          has_payload_o,
  output logic [BYTE_INDEX_W-1:0]       byte_index_o,
  output logic [7:0]                    payload_byte_o,
  output logic                          last_o
);

  fpp_wr_t   wr;
  fpp_desc_t desc;
  logic      desc_valid;
  logic      desc_pop;

  fpp_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .rx_byte_i   (rx_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .wr_o        (wr),
    .desc_valid_o(desc_valid),
    .desc_o      (desc),
    .desc_pop_i  (desc_pop)
  );

  fpp_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wr_i            (wr),
    .desc_valid_i    (desc_valid),
    .desc_i          (desc),
    .desc_pop_o      (desc_pop),
    .empty           (empty),
    .pop             (pop),
    .frame_address_o (frame_address_o),
    .frame_id_o      (frame_id_o),
    .payload_length_o(payload_length_o),
    .has_payload_o   (has_payload_o),
    .byte_index_o    (byte_index_o),
    .payload_byte_o  (payload_byte_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// tb: self-checking testbench for framed_packet_parser_checked_core
// depends on fpp_pkg and the core; streams directed and random frames through the parser
// and checks every popped word against a cycle-free frame predictor

module tb;
  import fpp_pkg::*;

  localparam int PAYLOAD_MAX = MAX_PAYLOAD_DEF;
  localparam int ITEMS = 320;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT = 5000;
  localparam logic [1:0] MODE_ZERO_A = 2'd2;
  localparam logic [1:0] MODE_ZERO_B = 2'd3;

  typedef enum logic [2:0] {
    P_HUNT, P_ADDR, P_ID, P_LEN, P_DATA, P_CHK_HI, P_CHK_LO
  } parse_phase_e;

  typedef struct packed {
    logic [7:0]               addr;
    logic [7:0]               id;
    logic [PAYLOAD_LEN_W-1:0] len;
    logic                     has_data;
    logic [BYTE_INDEX_W-1:0]  idx;
    logic [7:0]               data;
    logic                     last;
  } frame_word_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        typed;
    frame_word_t w;
  } stim_row_t;

  localparam stim_row_t DIRECTED [24] = '{
    '{8'hAA, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'h02, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hAD, 1'b1, '{8'h01, 8'h02, 6'd0, 1'b0, 5'd0, 8'h00, 1'b1}},
    '{8'h55, 1'b0, '0},
    '{8'hAA, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h21, 1'b0, '0},
    '{8'hAA, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0},
    '{8'hFF, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'hA9, 1'b1, '{8'hFF, 8'h00, 6'd1, 1'b1, 5'd0, 8'hFF, 1'b1}},
    '{8'hAA, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [7:0] rx_byte_i = 8'h00;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = REG_HEADER;
  logic [7:0] cfg_data_i = 8'h00;
  logic empty;
  logic pop = 1'b0;
  logic [7:0] frame_address_o;
  logic [7:0] frame_id_o;
  logic [PAYLOAD_LEN_W-1:0] payload_length_o;
  logic has_payload_o;
  logic [BYTE_INDEX_W-1:0] byte_index_o;
  logic [7:0] payload_byte_o;
  logic last_o;

  framed_packet_parser_checked_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .rx_byte_i(rx_byte_i),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .empty(empty), .pop(pop), .frame_address_o(frame_address_o), .frame_id_o(frame_id_o),
    .payload_length_o(payload_length_o), .has_payload_o(has_payload_o),
    .byte_index_o(byte_index_o), .payload_byte_o(payload_byte_o), .last_o(last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state and its copy of the registers
  logic [7:0]   hdr_sel = HEADER_RESET;
  logic [1:0]   mode_sel = MODE_SUM;
  parse_phase_e phase = P_HUNT;
  logic [5:0]   rcv_count = '0;
  logic [5:0]   held_len = '0;
  logic [7:0]   held_addr = '0;
  logic [7:0]   held_id = '0;
  logic [15:0]  run_chk = '0;
  logic [7:0]   chk_hi = '0;
  logic [7:0]   payload_buf [PAYLOAD_MAX];

  frame_word_t frame_words_q [$];
  int errors = 0;
  int bytes_sent = 0;
  int words_seen = 0;
  int frames_seen = 0;
  int tx_idle_pct = 16;
  int rx_idle_pct = 16;
  bit rx_hold_req = 1'b0;

  function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] b);
    logic fb;
    for (int k = 7; k >= 0; k--) begin
      fb = acc[15] ^ b[k];
      acc = {acc[14:0], 1'b0};
      if (fb) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

  function automatic logic [15:0] fold_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [7:0] s;
    s = acc[7:0] + b;
    case (mode_sel)
      MODE_SUM: return {8'h00, s};
      MODE_CRC: return crc16_update(acc, b);
      default:  return 16'h0000;
    endcase
  endfunction

  function automatic logic [15:0] frame_check_value();
    case (mode_sel)
      MODE_SUM: return {8'h00, run_chk[7:0]};
      MODE_CRC: return run_chk;
      default:  return 16'h0000;
    endcase
  endfunction

  task automatic parse_rx_byte(input logic [7:0] b, input bit record);
    frame_word_t w;
    case (phase)
      P_ADDR: begin
        held_addr = b;
        run_chk = fold_byte(run_chk, b);
        phase = P_ID;
      end
      P_ID: begin
        held_id = b;
        run_chk = fold_byte(run_chk, b);
        phase = P_LEN;
      end
      P_LEN: begin
        if (b > PAYLOAD_MAX) begin
          phase = P_HUNT;
        end else begin
          held_len = b[5:0];
          rcv_count = '0;
          run_chk = fold_byte(run_chk, b);
          phase = (b != 0) ? P_DATA : P_CHK_HI;
        end
      end
      P_DATA: begin
        if (rcv_count < PAYLOAD_MAX) begin
          payload_buf[rcv_count[4:0]] = b;
        end
        run_chk = fold_byte(run_chk, b);
        rcv_count = rcv_count + 1'b1;
        if (rcv_count >= held_len) begin
          phase = P_CHK_HI;
        end
      end
      P_CHK_HI: begin
        chk_hi = b;
        phase = P_CHK_LO;
      end
      P_CHK_LO: begin
        phase = P_HUNT;
        if ({chk_hi, b} == frame_check_value() && record) begin
          if (held_len == 0) begin
            frame_words_q.push_back(frame_word_t'{held_addr, held_id, '0, 1'b0, '0, 8'h00,
                                                  1'b1});
          end else begin
            for (int i = 0; i < held_len; i++) begin
              w.addr = held_addr;
              w.id = held_id;
              w.len = held_len;
              w.has_data = 1'b1;
              w.idx = i[BYTE_INDEX_W-1:0];
              w.data = payload_buf[i];
              w.last = (i + 1 == held_len);
              frame_words_q.push_back(w);
            end
          end
        end
      end
      default: begin
        if (b == hdr_sel) begin
          run_chk = fold_byte((mode_sel == MODE_CRC) ? CRC_INIT : 16'h0000, b);
          phase = P_ADDR;
        end
      end
    endcase
  endtask

  // returns at the rising edge that accepted the word
  task automatic push_byte(input logic [7:0] b, input bit record = 1'b1);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (full);
    parse_rx_byte(b, record);
    bytes_sent++;
  endtask

  function automatic logic [7:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 8'($urandom_range(6, 1));
    if (r < 65) return 8'd0;
    if (r < 88) return 8'($urandom_range(31, 7));
    return 8'(PAYLOAD_MAX);
  endfunction

  // advance the frame in progress by up to budget steps
  task automatic frame_steps(input int budget, input bit bad, input logic [7:0] len_byte);
    logic [15:0] chk;
    while (phase != P_HUNT && budget > 0) begin
      case (phase)
        P_LEN: push_byte(len_byte);
        P_CHK_HI: begin
          chk = frame_check_value();
          if (bad) begin
            chk = chk ^ (16'h0001 << $urandom_range(15));
          end
          push_byte(chk[15:8]);
          push_byte(chk[7:0]);
        end
        default: push_byte(8'($urandom_range(255)));
      endcase
      budget--;
    end
  endtask

  task automatic send_frame(input bit bad, input logic [7:0] len_byte);
    if (phase != P_HUNT) begin
      frame_steps(1000, 1'b0, pick_length());
    end
    push_byte(hdr_sel);
    frame_steps(1000, bad, len_byte);
  endtask

  task automatic cfg_write(input logic idx, input logic [7:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == REG_HEADER) begin
      hdr_sel = data;
    end else begin
      mode_sel = data[1:0];
    end
  endtask

  task automatic reconfigure(input logic [7:0] h, input logic [1:0] m);
    logic [5:0] junk;
    junk = 6'($urandom_range(63));
    @(negedge clk_i);
    push <= 1'b0;
    while (frame_words_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_write(REG_HEADER, h);
    cfg_write(REG_MODE, {junk, m});
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic bit field_matches(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // result checker
  initial begin
    frame_word_t want;
    frame_word_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        got = '{frame_address_o, frame_id_o, payload_length_o, has_payload_o,
                byte_index_o, payload_byte_o, last_o};
        words_seen++;
        if (got.last) frames_seen++;
        if (frame_words_q.size() == 0) begin
          $display("%0t: unexpected word, expected none actual %h", $time, got);
          errors++;
        end else begin
          want = frame_words_q.pop_front();
          errors += !field_matches("frame_address", want.addr, got.addr);
          errors += !field_matches("frame_id", want.id, got.id);
          errors += !field_matches("payload_length", want.len, got.len);
          errors += !field_matches("has_payload", want.has_data, got.has_data);
          errors += !field_matches("byte_index", want.idx, got.idx);
          errors += !field_matches("payload_byte", want.data, got.data);
          errors += !field_matches("last", want.last, got.last);
        end
      end
    end
  end

  // receiver side: random pop with one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        rx_hold_req = 1'b0;
      end
      pop <= rst_ni && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog on cycles without any accepted word
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int p;
    int r;
    int phase_start;
    logic [7:0] h;
    logic [1:0] m;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < 24; i++) begin
      push_byte(DIRECTED[i].b, !DIRECTED[i].typed);
      if (DIRECTED[i].typed) frame_words_q.push_back(DIRECTED[i].w);
    end

    p = 0;
    while (bytes_sent < ITEMS + 24) begin
      h = 8'($urandom_range(255));
      m = 2'($urandom_range(3));
      case (p)
        0: begin h = HEADER_RESET; m = MODE_SUM; end
        1: begin h = 8'h00; m = MODE_CRC; end
        2: begin h = 8'hFF; m = MODE_ZERO_A; end
        3: m = MODE_ZERO_B;
        4: m = MODE_CRC;
        default: ;
      endcase
      reconfigure(h, m);
      tx_idle_pct = (p == 5) ? 0 : 16;
      rx_idle_pct = (p == 5) ? 0 : 16;
      if (p == 4) begin
        rx_hold_req = 1'b1;
        repeat (6) send_frame(1'b0, 8'($urandom_range(6, 2)));
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 36) begin
        r = $urandom_range(99);
        if (r < 72) begin
          send_frame(1'b0, pick_length());
        end else if (r < 82) begin
          send_frame(1'b1, pick_length());
        end else if (r < 88) begin
          send_frame(1'b0, 8'($urandom_range(255, PAYLOAD_MAX + 1)));
        end else begin
          repeat ($urandom_range(4, 1)) begin
            push_byte(($urandom_range(3) == 0) ? hdr_sel : 8'($urandom_range(255)));
          end
        end
      end
      // sometimes leave a frame open across the register write
      if ($urandom_range(1)) begin
        if (phase == P_HUNT) push_byte(hdr_sel);
        frame_steps($urandom_range(5, 1), 1'b0, pick_length());
      end
      p++;
    end

    @(negedge clk_i);
    push <= 1'b0;
    while (frame_words_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d received bytes over %0d register settings, sum, crc and zero checks",
             bytes_sent, p + 1);
    $display("%0d result words in %0d frames, receiver held off %0d cycles once",
             words_seen, frames_seen, HOLD_CYCLES);
    if (errors == 0 && frame_words_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
